@@ hdl/ftt_pkg.sv @@
package ftt_pkg;

    // Field widths
    localparam int KEY_W   = 64;
    localparam int EP_W    = 48;
    localparam int SEQ_W   = 32;
    localparam int PKT_W   = 32;
    localparam int CONN_W  = 7;
    localparam int ERR_W   = 3;

    localparam int DEFAULT_TABLE_DEPTH = 64;

    // Error codes reported with each result
    typedef enum logic [ERR_W-1:0] {
        ERR_NONE         = 3'd0,
        ERR_NO_SYN       = 3'd1,
        ERR_SEQ_SET      = 3'd2,
        ERR_FIN_MISMATCH = 3'd3,
        ERR_FULL         = 3'd4
    } err_code_t;

    // Control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HIT,
        ST_NEW
    } state_t;

    // One connection record, everything but the key
    typedef struct packed {
        logic [EP_W-1:0]  init_ep;
        logic [EP_W-1:0]  resp_ep;
        logic [SEQ_W-1:0] init_seq;
        logic [SEQ_W-1:0] resp_seq;
        logic [PKT_W-1:0] first_pkt;
        logic [PKT_W-1:0] last_pkt;
        logic             resp_fin;
        logic             init_fin;
    } conn_rec_t;

    // Sequencer to key scanner
    typedef struct packed {
        logic start;
        logic wr_en;
    } scan_ctl_t;

    // Key scanner to sequencer
    typedef struct packed {
        logic done;
        logic hit;
    } scan_sts_t;

endpackage

@@ hdl/tcp_flow_tracking_table.sv @@
// Lookup: the stored keys are scanned in order, one key read a cycle, until a match or the
//   end of the stored entries; a new request is stalled until its result has been loaded.
// Reset: clears the entry count, sequencer and output valid; memories are not cleared,
//   since only entries below the count are ever read.
module tcp_flow_tracking_table #(
    parameter int TABLE_DEPTH = ftt_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [ftt_pkg::KEY_W-1:0]    flow_hash,
    input  logic [ftt_pkg::EP_W-1:0]     src_endpoint,
    input  logic [ftt_pkg::EP_W-1:0]     dst_endpoint,
    input  logic [ftt_pkg::SEQ_W-1:0]    seq_number,
    input  logic                         syn_flag,
    input  logic                         fin_flag,
    input  logic [ftt_pkg::PKT_W-1:0]    packet_number,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [ftt_pkg::CONN_W-1:0]   conn_index,
    output logic                         is_new,
    output logic [ftt_pkg::ERR_W-1:0]    error_code,
    output logic                         initiator_fin,
    output logic                         responder_fin
);
    import ftt_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          out_valid_reg, out_valid_next;

    // Request fields held for the whole operation
    logic [KEY_W-1:0] key_reg;
    logic [EP_W-1:0]  src_reg;
    logic [EP_W-1:0]  dst_reg;
    logic [SEQ_W-1:0] seq_reg;
    logic             syn_reg;
    logic             fin_reg;
    logic [PKT_W-1:0] pkt_reg;
    logic [IW-1:0]    hit_idx_reg;

    // Result payload
    logic [CONN_W-1:0] conn_index_reg;
    logic              is_new_reg;
    err_code_t         error_code_reg;
    logic              init_fin_reg;
    logic              resp_fin_reg;

    scan_ctl_t     scan_ctl;
    scan_sts_t     scan_sts;
    logic [IW-1:0] scan_hit_idx;

    conn_rec_t rec_mem [TABLE_DEPTH];
    conn_rec_t rec_rd_reg;
    conn_rec_t rec_wr_data;
    logic      rec_rd_en;
    logic      rec_wr_en;
    logic [IW-1:0] rec_wr_idx;

    logic accept;
    logic out_free;
    logic out_load;
    logic table_full;

    conn_rec_t         hit_rec;
    err_code_t         hit_err;
    conn_rec_t         new_rec;
    logic [CONN_W-1:0] res_conn;
    logic              res_new;
    err_code_t         res_err;
    logic              res_init_fin;
    logic              res_resp_fin;

    assign accept     = in_valid && !in_stall;
    assign in_stall   = (state_reg != ST_IDLE);
    assign out_free   = !out_valid_reg || !out_stall;
    assign table_full = (count_reg == CW'(TABLE_DEPTH));

    ftt_key_scan #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (scan_ctl),
        .key     (key_reg),
        .count   (count_reg),
        .wr_idx  (count_reg[IW-1:0]),
        .sts     (scan_sts),
        .hit_idx (scan_hit_idx)
    );

    // Hold the request fields on acceptance, and the matched index on a record read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg <= flow_hash;
            src_reg <= src_endpoint;
            dst_reg <= dst_endpoint;
            seq_reg <= seq_number;
            syn_reg <= syn_flag;
            fin_reg <= fin_flag;
            pkt_reg <= packet_number;
        end
        if (rec_rd_en)
        begin
            hit_idx_reg <= scan_hit_idx;
        end
    end

    // Record memory: read the matched entry, write it back modified, or write a new entry
    always_ff @(posedge clk)
    begin
        if (rec_wr_en)
        begin
            rec_mem[rec_wr_idx] <= rec_wr_data;
        end
        if (rec_rd_en)
        begin
            rec_rd_reg <= rec_mem[scan_hit_idx];
        end
    end

    // Update a known connection
    always_comb
    begin
        hit_rec          = rec_rd_reg;
        hit_err          = ERR_NONE;
        hit_rec.last_pkt = pkt_reg;
        if (syn_reg)
        begin
            if (rec_rd_reg.resp_seq == '0)
            begin
                hit_rec.resp_seq = seq_reg;
            end
            else
            begin
                hit_err = ERR_SEQ_SET;
            end
        end
        if (fin_reg)
        begin
            if (src_reg == rec_rd_reg.init_ep)
            begin
                hit_rec.init_fin = 1'b1;
            end
            else if (src_reg == rec_rd_reg.resp_ep)
            begin
                hit_rec.resp_fin = 1'b1;
            end
            else if (hit_err == ERR_NONE)
            begin
                hit_err = ERR_FIN_MISMATCH;
            end
        end
    end

    // Build a fresh connection record
    always_comb
    begin
        new_rec.init_ep   = src_reg;
        new_rec.resp_ep   = dst_reg;
        new_rec.init_seq  = seq_reg;
        new_rec.resp_seq  = '0;
        new_rec.first_pkt = pkt_reg;
        new_rec.last_pkt  = pkt_reg;
        new_rec.resp_fin  = 1'b0;
        new_rec.init_fin  = 1'b0;
    end

    // Sequence lookup, update and result
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_ctl.start = 1'b0;
        scan_ctl.wr_en = 1'b0;
        rec_rd_en      = 1'b0;
        rec_wr_en      = 1'b0;
        rec_wr_idx     = hit_idx_reg;
        rec_wr_data    = hit_rec;
        out_load       = 1'b0;
        res_conn       = CONN_W'(CW'(hit_idx_reg) + CW'(1));
        res_new        = 1'b0;
        res_err        = hit_err;
        res_init_fin   = hit_rec.init_fin;
        res_resp_fin   = hit_rec.resp_fin;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    scan_ctl.start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_sts.done)
                begin
                    if (scan_sts.hit)
                    begin
                        rec_rd_en  = 1'b1;
                        state_next = ST_HIT;
                    end
                    else
                    begin
                        state_next = ST_NEW;
                    end
                end
            end
            ST_HIT:
            begin
                if (out_free)
                begin
                    rec_wr_en  = 1'b1;
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_NEW:
            begin
                res_init_fin = 1'b0;
                res_resp_fin = 1'b0;
                if (table_full)
                begin
                    res_conn = '0;
                    res_err  = ERR_FULL;
                end
                else
                begin
                    res_conn = CONN_W'(count_reg + CW'(1));
                    res_new  = 1'b1;
                    res_err  = syn_reg ? ERR_NONE : ERR_NO_SYN;
                end
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                    if (!table_full)
                    begin
                        scan_ctl.wr_en = 1'b1;
                        rec_wr_en      = 1'b1;
                        rec_wr_idx     = count_reg[IW-1:0];
                        rec_wr_data    = new_rec;
                        count_next     = count_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on load, drop once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            conn_index_reg <= res_conn;
            is_new_reg     <= res_new;
            error_code_reg <= res_err;
            init_fin_reg   <= res_init_fin;
            resp_fin_reg   <= res_resp_fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign conn_index    = conn_index_reg;
    assign is_new        = is_new_reg;
    assign error_code    = error_code_reg;
    assign initiator_fin = init_fin_reg;
    assign responder_fin = resp_fin_reg;

endmodule

@@ hdl/ftt_key_scan.sv @@
module ftt_key_scan #(
    parameter int TABLE_DEPTH = ftt_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ftt_pkg::scan_ctl_t               ctl,
    input  logic [ftt_pkg::KEY_W-1:0]        key,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0] count,
    input  logic [$clog2(TABLE_DEPTH)-1:0]   wr_idx,
    output ftt_pkg::scan_sts_t               sts,
    output logic [$clog2(TABLE_DEPTH)-1:0]   hit_idx
);
    import ftt_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
    logic [KEY_W-1:0] key_rd_reg;
    logic [IW-1:0]    cmp_idx_reg;

    logic          busy_reg, busy_next;
    logic          cmp_valid_reg, cmp_valid_next;
    logic [CW-1:0] issue_idx_reg, issue_idx_next;

    logic rd_en;
    logic match;
    logic done;

    // Read one stored key a cycle, compare it the cycle after
    assign rd_en = busy_reg && (issue_idx_reg != count);
    assign match = cmp_valid_reg && (key_rd_reg == key);
    assign done  = busy_reg && (match || (!cmp_valid_reg && !rd_en));

    assign sts.done = done;
    assign sts.hit  = match;
    assign hit_idx  = cmp_idx_reg;

    // Key memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            key_mem[wr_idx] <= key;
        end
        if (rd_en)
        begin
            key_rd_reg  <= key_mem[issue_idx_reg[IW-1:0]];
            cmp_idx_reg <= issue_idx_reg[IW-1:0];
        end
    end

    // Advance the scan pointer, stop on a match or when the table is exhausted
    always_comb
    begin
        busy_next      = busy_reg;
        cmp_valid_next = cmp_valid_reg;
        issue_idx_next = issue_idx_reg;
        if (ctl.start)
        begin
            busy_next      = 1'b1;
            cmp_valid_next = 1'b0;
            issue_idx_next = '0;
        end
        else if (busy_reg)
        begin
            if (done)
            begin
                busy_next      = 1'b0;
                cmp_valid_next = 1'b0;
            end
            else
            begin
                cmp_valid_next = rd_en;
                if (rd_en)
                begin
                    issue_idx_next = issue_idx_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cmp_valid_reg <= 1'b0;
            issue_idx_reg <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cmp_valid_reg <= cmp_valid_next;
            issue_idx_reg <= issue_idx_next;
        end
    end

endmodule
